// ===== rtl/vsc_pkg.sv =====
// Types, constants and symbol mapping functions for the Vigenere stream cipher.
package vsc_pkg;

    localparam int unsigned KEY_SYM_W   = 6;
    localparam int unsigned KEY_SLOTS   = 8;
    localparam int unsigned KEY_W       = KEY_SYM_W * KEY_SLOTS;
    localparam int unsigned KEY_LEN_W   = 4;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned SUM_W       = KEY_SYM_W + 1;

    localparam logic [KEY_SYM_W-1:0] ALPHA_SIZE = 6'd55;
    localparam logic [KEY_SYM_W-1:0] SYM_MAX    = 6'd54;

    // Key "HDEBRU" as alphabet indices, symbol zero lowest.
    localparam logic [KEY_W-1:0]     KEY_RESET     = 48'd51211532194;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd6;

    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_SYMBOLS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LENGTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION   = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       message_start;
    } vsc_in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       not_in_alphabet;
    } vsc_out_t;

    // Map ASCII to alphabet index; ALPHA_SIZE marks a character outside it.
    function automatic logic [KEY_SYM_W-1:0] sym_index(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        priority if (ch >= "a" && ch <= "z") begin
            d = ch - 8'("a");
            return d[KEY_SYM_W-1:0];
        end else if (ch == " ") begin
            return 6'd26;
        end else if (ch >= "A" && ch <= "Z") begin
            d = ch - 8'("A") + 8'd27;
            return d[KEY_SYM_W-1:0];
        end else if (ch == ",") begin
            return 6'd53;
        end else if (ch == ".") begin
            return 6'd54;
        end else begin
            return ALPHA_SIZE;
        end
    endfunction

    // Map alphabet index back to ASCII.
    function automatic logic [7:0] sym_char(input logic [KEY_SYM_W-1:0] s);
        priority if (s < 6'd26) begin
            return 8'("a") + {2'b00, s};
        end else if (s == 6'd26) begin
            return 8'(" ");
        end else if (s < 6'd53) begin
            return 8'("A") + {2'b00, s} - 8'd27;
        end else if (s == 6'd53) begin
            return 8'(",");
        end else begin
            return 8'(".");
        end
    endfunction

endpackage

// ===== rtl/vigenere_stream_cipher.sv =====
// Vigenere stream cipher over a 55-symbol alphabet, one character per item.
// An item passes the input register and then the result register before its result can be accepted.
// Throughput: one item per cycle while m_ready is high; input register and result register each hold one item.
// The input side keeps accepting while a result waits if the input register is free.
// Reset (aresetn low, synchronous): empties both registers, key position to zero,
// key "HDEBRU", key length 6, encrypt direction.
module vigenere_stream_cipher
    import vsc_pkg::*;
#(
    parameter int unsigned KEY_MAX = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [KEY_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vsc_in_t               s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vsc_out_t              m_item
);

    localparam int unsigned POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam logic [KEY_LEN_W-1:0] LEN_MAX = KEY_LEN_W'(KEY_MAX);

    logic [KEY_W-1:0]     key_symbols_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic                 direction_reg;
    logic [POS_W-1:0]     key_position_reg;
    logic [POS_W-1:0]     key_position_next;

    logic                 in_valid_reg;
    vsc_in_t              in_item_reg;
    logic                 m_valid_reg;
    vsc_out_t             m_item_reg;
    vsc_out_t             m_item_next;

    logic                 advance;
    logic [KEY_LEN_W-1:0] len_eff;
    logic [KEY_LEN_W-1:0] pos_raw;
    logic [KEY_LEN_W-1:0] pos_use;
    logic [KEY_LEN_W-1:0] pos_inc;
    logic [2:0]           slot;
    logic [KEY_SYM_W-1:0] key_raw;
    logic [KEY_SYM_W-1:0] key_sym;
    logic [KEY_SYM_W-1:0] idx;
    logic [SUM_W-1:0]     addend;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     res;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        priority if (key_length_reg == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (key_length_reg > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = key_length_reg;
        end

        pos_raw = in_item_reg.message_start ? '0 : KEY_LEN_W'(key_position_reg);
        pos_use = (pos_raw >= len_eff) ? '0 : pos_raw;
        pos_inc = pos_use + KEY_LEN_W'(1);
        key_position_next = (pos_inc >= len_eff) ? '0 : POS_W'(pos_inc);

        slot    = pos_use[2:0];
        key_raw = key_symbols_reg[KEY_SYM_W*slot +: KEY_SYM_W];
        key_sym = (key_raw > SYM_MAX) ? SYM_MAX : key_raw;

        idx    = sym_index(in_item_reg.char_in);
        addend = direction_reg ? ({1'b0, ALPHA_SIZE} - {1'b0, key_sym}) : {1'b0, key_sym};
        sum    = {1'b0, idx} + addend;
        res    = (sum >= {1'b0, ALPHA_SIZE}) ? (sum - {1'b0, ALPHA_SIZE}) : sum;

        if (idx == ALPHA_SIZE) begin
            m_item_next.char_out        = in_item_reg.char_in;
            m_item_next.not_in_alphabet = 1'b1;
        end else begin
            m_item_next.char_out        = sym_char(res[KEY_SYM_W-1:0]);
            m_item_next.not_in_alphabet = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_symbols_reg <= KEY_RESET;
            key_length_reg  <= KEY_LEN_RESET;
            direction_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_KEY_SYMBOLS: key_symbols_reg <= cfg_wdata;
                CFG_KEY_LENGTH:  key_length_reg  <= cfg_wdata[KEY_LEN_W-1:0];
                CFG_DIRECTION:   direction_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            key_position_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg      <= 1'b1;
                key_position_reg <= key_position_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule

// ===== rtl/vsc_checker.sv =====
// Port-level checks for the Vigenere stream cipher, bound to the top level.
module vsc_checker
    import vsc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic [CFG_ADDR_W-1:0] cfg_addr,
    input logic [KEY_W-1:0]      cfg_wdata,
    input logic                  s_valid,
    input logic                  s_ready,
    input vsc_in_t               s_item,
    input logic                  m_valid,
    input logic                  m_ready,
    input vsc_out_t              m_item
);

    logic in_alpha;

    assign in_alpha = (m_item.char_out >= "a" && m_item.char_out <= "z") ||
                      (m_item.char_out >= "A" && m_item.char_out <= "Z") ||
                      m_item.char_out == " " || m_item.char_out == "," ||
                      m_item.char_out == ".";

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_flag_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.not_in_alphabet |-> !in_alpha)
        else $error("flagged item carries an alphabet character");

    a_clear_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.not_in_alphabet |-> in_alpha)
        else $error("unflagged item carries a character outside the alphabet");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result item waiting");

endmodule

bind vigenere_stream_cipher vsc_checker u_vsc_checker (.*);

// ===== verif/vigenere_stream_cipher_test.sv =====
// Self-checking testbench for the Vigenere stream cipher: predicted items against the result stream.
module vigenere_stream_cipher_test;
    import vsc_pkg::*;

    localparam int unsigned KEY_MAX        = 8;
    localparam int unsigned ALPHA_LEN      = 55;
    localparam int unsigned SYM_TOP        = 54;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned RX_HOLD_CYCLES = 150;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [8*ALPHA_LEN-1:0] ALPHABET =
        "abcdefghijklmnopqrstuvwxyz ABCDEFGHIJKLMNOPQRSTUVWXYZ,.";

    typedef enum {RX_FREE, RX_HALF, RX_SPARSE} rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [KEY_W-1:0]      cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    vsc_in_t               s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    vsc_out_t              m_item;

    // cipher state as the block should hold it
    logic [KEY_W-1:0] key_syms = KEY_RESET;
    logic [3:0]       key_len  = KEY_LEN_RESET;
    logic             dir      = 1'b0;
    logic [2:0]       key_pos  = 3'd0;

    vsc_in_t  pend_q[$];
    vsc_out_t cipher_q[$];

    int unsigned mismatches    = 0;
    int unsigned cycles        = 0;
    int unsigned tx_burst_left = 1;
    int unsigned tx_gap_left   = 0;
    int unsigned rx_hold_asked = 0;
    int unsigned rx_hold_done  = 0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_seg_left   = 0;
    rx_mode_t    rx_mode       = RX_FREE;

    vigenere_stream_cipher #(.KEY_MAX(KEY_MAX)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    function automatic logic [7:0] glyph(input int unsigned i);
        return ALPHABET[8*(ALPHA_LEN-1-i) +: 8];
    endfunction

    function automatic int unsigned alpha_pos(input logic [7:0] ch);
        for (int i = 0; i < ALPHA_LEN; i++) begin
            if (glyph(i) == ch) return i;
        end
        return ALPHA_LEN;
    endfunction

    function automatic vsc_out_t cipher_predict(input vsc_in_t it);
        int unsigned len, pos, k, idx;
        vsc_out_t r;
        len = (key_len == 0) ? 1 : ((key_len > KEY_MAX) ? KEY_MAX : key_len);
        pos = it.message_start ? 0 : key_pos;
        if (pos >= len) pos = 0;
        k = key_syms[KEY_SYM_W*pos +: KEY_SYM_W];
        if (k > SYM_TOP) k = SYM_TOP;
        idx = alpha_pos(it.char_in);
        if (idx == ALPHA_LEN) begin
            r.char_out        = it.char_in;
            r.not_in_alphabet = 1'b1;
        end else begin
            r.char_out        = dir ? glyph((idx + ALPHA_LEN - k) % ALPHA_LEN)
                                    : glyph((idx + k) % ALPHA_LEN);
            r.not_in_alphabet = 1'b0;
        end
        key_pos = (pos + 1 >= len) ? 3'd0 : 3'(pos + 1);
        return r;
    endfunction

    function automatic void add_item(input logic [7:0] ch, input logic start);
        vsc_in_t it;
        it.char_in       = ch;
        it.message_start = start;
        pend_q.push_back(it);
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 99) < 85) return glyph($urandom_range(0, SYM_TOP));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [KEY_W-1:0] rand_word();
        return KEY_W'({$urandom(), $urandom()});
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [KEY_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_KEY_SYMBOLS: key_syms = val;
            CFG_KEY_LENGTH:  key_len  = val[3:0];
            CFG_DIRECTION:   dir      = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_length(input logic [3:0] len);
        logic [KEY_W-1:0] v;
        v      = rand_word();
        v[3:0] = len;
        write_reg(CFG_KEY_LENGTH, v);
    endtask

    task automatic write_direction(input logic d);
        logic [KEY_W-1:0] v;
        v    = rand_word();
        v[0] = d;
        write_reg(CFG_DIRECTION, v);
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || s_valid || cipher_q.size() != 0) @(posedge aclk);
    endtask

    task automatic rand_config();
        logic [KEY_W-1:0] key;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        for (int s = 0; s < KEY_SLOTS; s++) begin
            if (pick < 60)
                key[KEY_SYM_W*s +: KEY_SYM_W] = KEY_SYM_W'($urandom_range(0, SYM_TOP));
            else if (pick < 85)
                key[KEY_SYM_W*s +: KEY_SYM_W] = KEY_SYM_W'($urandom_range(0, 63));
            else
                key[KEY_SYM_W*s +: KEY_SYM_W] = KEY_SYM_W'($urandom_range(55, 63));
        end
        write_reg(CFG_KEY_SYMBOLS, key);
        if ($urandom_range(0, 9) < 7) write_length(4'($urandom_range(1, KEY_MAX)));
        else                          write_length(4'($urandom_range(0, 15)));
        write_direction(1'($urandom_range(0, 1)));
    endtask

    task automatic queue_traffic(input int unsigned n);
        int unsigned sent, len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++) add_item(rand_char(), i == 0);
            end else begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            sent += len;
        end
    endtask

    always @(posedge aclk) begin : drive_items
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) cipher_q.push_back(cipher_predict(s_item));
            if (tx_gap_left == 0 && pend_q.size() != 0) begin
                s_item  <= pend_q.pop_front();
                s_valid <= 1'b1;
                tx_burst_left--;
                if (tx_burst_left == 0) begin
                    tx_burst_left = $urandom_range(1, 30);
                    tx_gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
                if (tx_gap_left != 0) tx_gap_left--;
            end
        end
    end

    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_hold_done != rx_hold_asked) begin
            rx_hold_done++;
            rx_hold_left = RX_HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (rx_seg_left == 0) begin
                rx_mode     = rx_mode_t'($urandom_range(0, 2));
                rx_seg_left = $urandom_range(1, 40);
            end
            rx_seg_left--;
            case (rx_mode)
                RX_FREE: m_ready <= 1'b1;
                RX_HALF: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_items
        vsc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cipher_q.size() == 0) begin
                $error("unexpected item: char_out %h not_in_alphabet %b",
                       m_item.char_out, m_item.not_in_alphabet);
                mismatches++;
            end else begin
                want = cipher_q.pop_front();
                if (m_item.char_out !== want.char_out) begin
                    $error("char_out: expected %h, got %h", want.char_out, m_item.char_out);
                    mismatches++;
                end
                if (m_item.not_in_alphabet !== want.not_in_alphabet) begin
                    $error("not_in_alphabet: expected %b, got %b",
                           want.not_in_alphabet, m_item.not_in_alphabet);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) @(posedge aclk);
        $display("[vigenere_stream_cipher] ERROR");
        $finish;
    end

    initial begin : run
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        add_item("a", 1'b1);
        add_item("z", 1'b0);
        add_item(" ", 1'b0);
        add_item("A", 1'b0);
        add_item("Z", 1'b0);
        add_item(",", 1'b0);
        add_item(".", 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h60, 1'b0);
        add_item(8'h7B, 1'b0);
        add_item(8'h40, 1'b0);
        add_item(8'h5B, 1'b0);
        add_item(8'h2B, 1'b0);
        add_item(8'h2D, 1'b0);
        add_item(8'h2F, 1'b0);
        add_item(8'h1F, 1'b1);
        add_item(8'h80, 1'b0);
        add_item("q", 1'b1);
        add_item("Q", 1'b0);
        wait_idle();

        // ignored register, keys above the top symbol, zero length, decrypt
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_KEY_SYMBOLS, '1);
        write_length(4'd0);
        write_direction(1'b1);
        add_item("a", 1'b1);
        add_item(".", 1'b0);
        add_item(" ", 1'b0);
        wait_idle();

        write_reg(CFG_KEY_SYMBOLS, '0);
        write_length(4'd15);
        write_direction(1'b0);
        add_item("m", 1'b1);
        for (int i = 0; i < 9; i++) add_item(rand_char(), 1'b0);
        wait_idle();

        // shorten the key while the position sits past the new length
        write_reg(CFG_KEY_SYMBOLS, rand_word());
        write_length(4'd8);
        add_item("b", 1'b1);
        for (int i = 0; i < 5; i++) add_item("c", 1'b0);
        wait_idle();
        write_length(4'd3);
        add_item("k", 1'b0);
        add_item("l", 1'b0);
        add_item("m", 1'b0);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            rand_config();
            queue_traffic(130);
            if (p % 4 == 1) rx_hold_asked++;
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[vigenere_stream_cipher] OK");
        end else begin
            $display("[vigenere_stream_cipher] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vsc_pkg.sv
rtl/vigenere_stream_cipher.sv
rtl/vsc_checker.sv
verif/vigenere_stream_cipher_test.sv
